// ----- design/ubt_pkg.sv -----
`timescale 1ns / 1ps

package ubt_pkg;

  // Default build parameters
  localparam int DATA_BITS_DEF  = 8;
  localparam int TIMER_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_WIDTH      = 16;
  localparam int CFG_INDEX_W    = 1;
  localparam int BYTE_W         = 8;

  localparam logic [CFG_WIDTH-1:0] BIT_TICKS_RESET          = 16'd104;
  localparam logic [CFG_WIDTH-1:0] FIRST_SAMPLE_TICKS_RESET = 16'd143;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BIT_TICKS          = 1'b0,
    REG_FIRST_SAMPLE_TICKS = 1'b1
  } cfg_reg_t;

  // Per-tick transmitter outcome
  typedef struct packed {
    logic line;
    logic taken;
    logic ready;
  } tx_res_t;

  // Per-tick receiver outcome
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } rx_res_t;

endpackage

// ----- design/ubt_tx.sv -----
`timescale 1ns / 1ps

module ubt_tx #(
  parameter int DATA_BITS  = ubt_pkg::DATA_BITS_DEF,
  parameter int TIMER_BITS = ubt_pkg::TIMER_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [TIMER_BITS-1:0]       bit_load,
  input  logic                        tx_valid,
  input  logic [ubt_pkg::BYTE_W-1:0]  tx_byte,
  output ubt_pkg::tx_res_t            res
);

  localparam int PW = $clog2(DATA_BITS + 3);
  localparam int IW = $clog2(DATA_BITS);
  localparam logic [PW-1:0] PH_IDLE  = PW'(0);
  localparam logic [PW-1:0] PH_START = PW'(1);
  localparam logic [PW-1:0] PH_STOP  = PW'(DATA_BITS + 2);

  logic [PW-1:0]         phase, phase_next, phase_run;
  logic [TIMER_BITS-1:0] countdown, countdown_next;
  logic [DATA_BITS-1:0]  shift, shift_next;
  logic [PW-1:0]         data_idx;
  logic                  ready;
  logic                  taken;

  always_comb begin
    phase_run      = phase;
    countdown_next = countdown;
    shift_next     = shift;
    // finish the running bit period
    if (phase >= PH_START && phase <= PH_STOP) begin
      if (countdown == '0) begin
        if (phase == PH_STOP) begin
          phase_run = PH_IDLE;
        end else begin
          phase_run      = phase + PW'(1);
          countdown_next = bit_load;
        end
      end else begin
        countdown_next = countdown - TIMER_BITS'(1);
      end
    end else begin
      phase_run = PH_IDLE;
    end
    ready      = (phase_run == PH_IDLE);
    taken      = ready && tx_valid;
    phase_next = phase_run;
    if (taken) begin
      shift_next     = DATA_BITS'(tx_byte);
      phase_next     = PH_START;
      countdown_next = bit_load;
    end
    data_idx = phase_next - PW'(2);
    if (phase_next == PH_START) begin
      res.line = 1'b0;
    end else if (phase_next > PH_START && phase_next < PH_STOP) begin
      res.line = shift_next[data_idx[IW-1:0]];
    end else begin
      res.line = 1'b1;
    end
    res.taken = taken;
    res.ready = ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      countdown <= '0;
    end else if (advance) begin
      phase     <= phase_next;
      countdown <= countdown_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      shift <= shift_next;
    end
  end

endmodule

// ----- design/ubt_rx.sv -----
`timescale 1ns / 1ps

module ubt_rx #(
  parameter int DATA_BITS  = ubt_pkg::DATA_BITS_DEF,
  parameter int TIMER_BITS = ubt_pkg::TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [TIMER_BITS-1:0] bit_load,
  input  logic [TIMER_BITS-1:0] first_load,
  input  logic                  rx_line,
  output ubt_pkg::rx_res_t      res
);

  localparam int PW = $clog2(DATA_BITS + 2);
  localparam int IW = $clog2(DATA_BITS);
  localparam int HW = (DATA_BITS < ubt_pkg::BYTE_W) ? DATA_BITS : ubt_pkg::BYTE_W;
  localparam logic [PW-1:0] PH_HUNT = PW'(0);
  localparam logic [PW-1:0] PH_TAIL = PW'(DATA_BITS + 1);

  logic [PW-1:0]                phase, phase_next;
  logic [TIMER_BITS-1:0]        countdown, countdown_next;
  logic [DATA_BITS-1:0]         shift, shift_next;
  logic [ubt_pkg::BYTE_W-1:0]   held, held_next;
  logic [PW-1:0]                bit_idx;
  logic                         done;

  always_comb begin
    phase_next     = phase;
    countdown_next = countdown;
    shift_next     = shift;
    held_next      = held;
    done           = 1'b0;
    bit_idx        = phase - PW'(1);
    if (phase == PH_HUNT) begin
      if (!rx_line) begin
        phase_next     = PW'(1);
        shift_next     = '0;
        countdown_next = first_load;
      end
    end else if (phase < PH_TAIL) begin
      if (countdown == '0) begin
        shift_next[bit_idx[IW-1:0]] = rx_line;
        phase_next     = phase + PW'(1);
        countdown_next = bit_load;
      end else begin
        countdown_next = countdown - TIMER_BITS'(1);
      end
    end else if (phase == PH_TAIL) begin
      if (countdown == '0) begin
        done       = 1'b1;
        held_next  = ubt_pkg::BYTE_W'(shift[HW-1:0]);
        phase_next = PH_HUNT;
      end else begin
        countdown_next = countdown - TIMER_BITS'(1);
      end
    end else begin
      phase_next = PH_HUNT;
    end
    res.valid = done;
    res.data  = held_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      countdown <= '0;
      held      <= '0;
    end else if (advance) begin
      phase     <= phase_next;
      countdown <= countdown_next;
      held      <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      shift <= shift_next;
    end
  end

endmodule

// ----- design/uart_bit_transceiver_unit.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// config    in         cfg_we                 cfg_index, cfg_data
// tick in   in         in_valid / in_stall    tx_valid, tx_byte, rx_line
// tick out  out        out_valid / out_stall  tx_line, tx_taken, tx_ready, rx_valid, rx_byte
//
// One timer tick is taken per cycle while no stall holds the input; its result appears
// in the output register on the next cycle and is held there while out_stall is high.
// The output register is the only buffer: a new tick is taken when it is empty or is
// being drained in the same cycle, so in_stall follows out_stall while a result waits.
// rst is synchronous: both engines return to idle/hunt, the held byte clears to zero and
// the bit period registers return to 104 and 143 ticks.

module uart_bit_transceiver_unit #(
  parameter int DATA_BITS  = ubt_pkg::DATA_BITS_DEF,
  parameter int TIMER_BITS = ubt_pkg::TIMER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [ubt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ubt_pkg::CFG_WIDTH-1:0]     cfg_data,
  // tick input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              tx_valid,
  input  logic [ubt_pkg::BYTE_W-1:0]        tx_byte,
  input  logic                              rx_line,
  // tick result
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              tx_line,
  output logic                              tx_taken,
  output logic                              tx_ready,
  output logic                              rx_valid,
  output logic [ubt_pkg::BYTE_W-1:0]        rx_byte
);

  // width wide enough for both the register and the timer limit
  localparam int CW = (TIMER_BITS > ubt_pkg::CFG_WIDTH) ? TIMER_BITS : ubt_pkg::CFG_WIDTH;

  logic [ubt_pkg::CFG_WIDTH-1:0] bit_ticks;
  logic [ubt_pkg::CFG_WIDTH-1:0] first_sample_ticks;
  logic [TIMER_BITS-1:0]         bit_load;
  logic [TIMER_BITS-1:0]         first_load;
  logic                          advance;
  ubt_pkg::tx_res_t              tx_res;
  ubt_pkg::rx_res_t              rx_res;

  // Turn a period in ticks into a countdown reload: zero acts as one, anything above
  // the timer range saturates, then subtract one.
  function automatic logic [TIMER_BITS-1:0] reload(input logic [ubt_pkg::CFG_WIDTH-1:0] ticks);
    logic [CW-1:0] ext;
    logic [CW-1:0] lim;
    logic [CW-1:0] sat;
    ext = CW'(ticks);
    lim = CW'({TIMER_BITS{1'b1}});
    sat = (ext > lim) ? lim : ext;
    if (sat == '0) begin
      return '0;
    end
    return TIMER_BITS'(sat - CW'(1));
  endfunction

  assign bit_load   = reload(bit_ticks);
  assign first_load = reload(first_sample_ticks);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks          <= ubt_pkg::BIT_TICKS_RESET;
      first_sample_ticks <= ubt_pkg::FIRST_SAMPLE_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (ubt_pkg::cfg_reg_t'(cfg_index))
        ubt_pkg::REG_BIT_TICKS:          bit_ticks          <= cfg_data;
        ubt_pkg::REG_FIRST_SAMPLE_TICKS: first_sample_ticks <= cfg_data;
      endcase
    end
  end

  // take a tick whenever the result slot is free or draining this cycle
  assign in_stall = out_valid && out_stall;
  assign advance  = in_valid && !in_stall;

  ubt_tx #(
    .DATA_BITS  (DATA_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_tx (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .bit_load (bit_load),
    .tx_valid (tx_valid),
    .tx_byte  (tx_byte),
    .res      (tx_res)
  );

  ubt_rx #(
    .DATA_BITS  (DATA_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_rx (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .bit_load   (bit_load),
    .first_load (first_load),
    .rx_line    (rx_line),
    .res        (rx_res)
  );

  // result register: hold while stalled, load on every accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx_line  <= tx_res.line;
      tx_taken <= tx_res.taken;
      tx_ready <= tx_res.ready;
      rx_valid <= rx_res.valid;
      rx_byte  <= rx_res.data;
    end
  end

endmodule

// ----- test/uart_bit_transceiver_unit_test.sv -----
`timescale 1ns / 1ps

module uart_bit_transceiver_unit_test;

  // Transmitter phases: idle, start bit, eight data bits, stop bit
  localparam logic [3:0] TXP_IDLE  = 4'd0;
  localparam logic [3:0] TXP_START = 4'd1;
  localparam logic [3:0] TXP_STOP  = 4'd10;
  // Receiver phases: hunting, eight data samples, tail period
  localparam logic [3:0] RXP_HUNT  = 4'd0;
  localparam logic [3:0] RXP_TAIL  = 4'd9;
  localparam int         FRAME_BITS = 10;

  typedef struct packed {
    ubt_pkg::tx_res_t tx;
    ubt_pkg::rx_res_t rx;
  } tick_out_t;

  // Where the receive line level comes from during random traffic
  typedef enum {SRC_FRAMED, SRC_LOOPBACK, SRC_NOISE} line_src_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [ubt_pkg::CFG_INDEX_W-1:0] cfg_index = ubt_pkg::REG_BIT_TICKS;
  logic [ubt_pkg::CFG_WIDTH-1:0]   cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              tx_valid = 1'b0;
  logic [ubt_pkg::BYTE_W-1:0] tx_byte = '0;
  logic              rx_line = 1'b1;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              tx_line;
  logic              tx_taken;
  logic              tx_ready;
  logic              rx_valid;
  logic [ubt_pkg::BYTE_W-1:0] rx_byte;

  uart_bit_transceiver_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .tx_valid(tx_valid),
    .tx_byte(tx_byte),
    .rx_line(rx_line),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .tx_line(tx_line),
    .tx_taken(tx_taken),
    .tx_ready(tx_ready),
    .rx_valid(rx_valid),
    .rx_byte(rx_byte)
  );

  always #1 clk = ~clk;

  // Idling controls shared by the sender, the drain process and the tests
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int hold_off_len = 0;
  int mismatches = 0;

  // Outcomes predicted for accepted ticks, oldest first
  tick_out_t tick_outcomes[$];

  // Predictor state: register copies and both serial engines
  logic [15:0] period_ticks;
  logic [15:0] sample_ticks;
  logic [3:0]  txm_phase;
  logic [15:0] txm_count;
  logic [7:0]  txm_data;
  logic [3:0]  rxm_phase;
  logic [15:0] rxm_count;
  logic [7:0]  rxm_data;
  logic [7:0]  rxm_last;
  logic        model_tx_line;

  // Framed receive-line source
  logic [FRAME_BITS-1:0] gen_frame;
  int gen_bit = FRAME_BITS;
  int gen_left;
  int gen_period;

  // A programmed period of zero behaves as one tick
  function automatic int ticks_of(input logic [15:0] t);
    return (t == 16'd0) ? 1 : int'(t);
  endfunction

  function automatic void reset_model();
    period_ticks  = ubt_pkg::BIT_TICKS_RESET;
    sample_ticks  = ubt_pkg::FIRST_SAMPLE_TICKS_RESET;
    txm_phase     = TXP_IDLE;
    txm_count     = '0;
    txm_data      = '0;
    rxm_phase     = RXP_HUNT;
    rxm_count     = '0;
    rxm_data      = '0;
    rxm_last      = '0;
    model_tx_line = 1'b1;
  endfunction

  // Advance both engines by one tick and return the outcome the block must show
  function automatic tick_out_t advance_tick(input logic tv, input logic [7:0] tb,
                                             input logic rl);
    tick_out_t o;
    o = '0;

    // transmitter: finish the running bit period first, then consider the offer
    if (txm_phase != TXP_IDLE) begin
      if (txm_count == 16'd0) begin
        if (txm_phase == TXP_STOP) begin
          txm_phase = TXP_IDLE;
        end else begin
          txm_phase = txm_phase + 4'd1;
          txm_count = 16'(ticks_of(period_ticks) - 1);
        end
      end else begin
        txm_count = txm_count - 16'd1;
      end
    end
    o.tx.ready = (txm_phase == TXP_IDLE);
    o.tx.taken = o.tx.ready && tv;
    if (o.tx.taken) begin
      txm_data  = tb;
      txm_phase = TXP_START;
      txm_count = 16'(ticks_of(period_ticks) - 1);
    end
    if (txm_phase == TXP_START) begin
      o.tx.line = 1'b0;
    end else if (txm_phase > TXP_START && txm_phase < TXP_STOP) begin
      o.tx.line = txm_data[txm_phase - 4'd2];
    end else begin
      o.tx.line = 1'b1;
    end

    // receiver: hunt, sample each bit at its countdown end, then wait the tail out
    if (rxm_phase == RXP_HUNT) begin
      if (!rl) begin
        rxm_phase = 4'd1;
        rxm_data  = '0;
        rxm_count = 16'(ticks_of(sample_ticks) - 1);
      end
    end else if (rxm_phase < RXP_TAIL) begin
      if (rxm_count == 16'd0) begin
        rxm_data[rxm_phase - 4'd1] = rl;
        rxm_phase = rxm_phase + 4'd1;
        rxm_count = 16'(ticks_of(period_ticks) - 1);
      end else begin
        rxm_count = rxm_count - 16'd1;
      end
    end else begin
      if (rxm_count == 16'd0) begin
        o.rx.valid = 1'b1;
        rxm_last   = rxm_data;
        rxm_phase  = RXP_HUNT;
      end else begin
        rxm_count = rxm_count - 16'd1;
      end
    end
    o.rx.data = rxm_last;

    model_tx_line = o.tx.line;
    return o;
  endfunction

  // Next level of a stream of well-formed frames at about the programmed bit rate
  function automatic logic serial_level();
    logic level;
    int r;
    if (gen_bit >= FRAME_BITS) begin
      // leave the line idle now and then between frames
      if ($urandom_range(0, 2) == 0) return 1'b1;
      gen_frame  = {1'b1, 8'($urandom), 1'b0};
      gen_bit    = 0;
      gen_period = ticks_of(period_ticks);
      // skew a few frames by a tick either way
      r = $urandom_range(0, 7);
      if (r == 0) gen_period++;
      else if (r == 1 && gen_period > 1) gen_period--;
      gen_left = gen_period;
    end
    level = gen_frame[gen_bit];
    gen_left--;
    if (gen_left == 0) begin
      gen_bit++;
      gen_left = gen_period;
    end
    return level;
  endfunction

  // Mostly no pause, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one tick and hold it until the block takes the transfer, then predict it.
  // valid stays high on return so that back-to-back ticks need one assignment only.
  task automatic send_tick(input logic tv, input logic [7:0] tb, input logic rl);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    tx_valid <= tv;
    tx_byte  <= tb;
    rx_line  <= rl;
    do @(posedge clk); while (in_stall);
    tick_outcomes.push_back(advance_tick(tv, tb, rl));
  endtask

  // Program both bit periods once every predicted outcome has drained.
  // The serial engines keep running state across this; only the handshake is idle.
  task automatic configure(input logic [15:0] bt, input logic [15:0] fs);
    in_valid <= 1'b0;
    while (tick_outcomes.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ubt_pkg::REG_BIT_TICKS;
    cfg_data  <= bt;
    @(posedge clk);
    period_ticks = bt;
    cfg_index <= ubt_pkg::REG_FIRST_SAMPLE_TICKS;
    cfg_data  <= fs;
    @(posedge clk);
    sample_ticks = fs;
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      // report the first hundred only
      if (mismatches <= 100)
        $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    tick_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tick_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 100)
          $display("%0t ns: result transfer with no tick outstanding, expected none, got %0h",
                   $time, {tx_line, tx_taken, tx_ready, rx_valid, rx_byte});
      end else begin
        want = tick_outcomes.pop_front();
        check_field("tx_line",  8'(want.tx.line),  8'(tx_line));
        check_field("tx_taken", 8'(want.tx.taken), 8'(tx_taken));
        check_field("tx_ready", 8'(want.tx.ready), 8'(tx_ready));
        check_field("rx_valid", 8'(want.rx.valid), 8'(rx_valid));
        check_field("rx_byte",  want.rx.data,      rx_byte);
      end
    end
  end

  // Result side: stall at random, or hold off for a requested number of cycles
  initial begin : result_drain
    int n;
    @(posedge clk);
    forever begin
      if (hold_off_len > 0) begin
        n = hold_off_len;
        hold_off_len = 0;
      end else if (stalls_on) begin
        n = pick_gap();
      end else begin
        n = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Reset values: transmitter ready, line high, no byte held yet
  task automatic test_reset_state();
    int i;
    for (i = 0; i < 3; i++) send_tick(1'b0, 8'h00, 1'b1);
  endtask

  task automatic test_corner_cases();
    logic [FRAME_BITS-1:0] frame;
    int i;
    // zero periods behave as one tick per bit; send all ones, receive all zeros
    configure(16'd0, 16'd0);
    send_tick(1'b1, 8'hFF, 1'b1);
    frame = {1'b1, 8'h00, 1'b0};
    // keep offering while busy: those offers must be ignored until the frame ends
    for (i = 0; i < FRAME_BITS; i++) send_tick(1'b1, 8'h00, frame[i]);
    // a one-tick glitch still starts a reception, which reads all ones
    configure(16'd1, 16'd2);
    send_tick(1'b1, 8'h00, 1'b0);
    for (i = 0; i < 12; i++) send_tick(1'b0, 8'hFF, 1'b1);
  endtask

  // Load both timers with long periods, then shorten the period mid-frame:
  // the change must only show from the next bit period on
  task automatic test_long_period();
    int i;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    configure(16'd200, 16'd250);
    send_tick(1'b1, 8'($urandom), 1'b0);
    configure(16'd2, 16'd3);
    for (i = 0; i < 300; i++) send_tick(i == 100, 8'($urandom), 1'b1);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Hold the result side off while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    int i;
    gaps_on = 1'b0;
    configure(16'd2, 16'd3);
    hold_off_len = 80;
    for (i = 0; i < 120; i++)
      send_tick($urandom_range(0, 1) == 1, 8'($urandom), serial_level());
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int sent;
    int seg_len;
    int i;
    int pick;
    logic [15:0] bt;
    logic [15:0] fs;
    line_src_t src;
    logic rl;
    sent = 0;
    src = SRC_FRAMED;
    while (sent < 1000) begin
      bt = 16'($urandom_range(1, 6));
      case ($urandom_range(0, 3))
        0: fs = (bt * 16'd11) / 16'd8;
        1: fs = bt;
        2: fs = 16'($urandom_range(1, 3 * int'(bt)));
        default: fs = bt + 16'($urandom_range(0, 2));
      endcase
      configure(bt, fs);
      seg_len = $urandom_range(80, 220);
      for (i = 0; i < seg_len; i++) begin
        // switch the line source every so often; switching mid-frame breaks frames
        if (i % 40 == 0) begin
          pick = $urandom_range(0, 9);
          if (pick < 5) src = SRC_FRAMED;
          else if (pick < 8) src = SRC_LOOPBACK;
          else src = SRC_NOISE;
        end
        case (src)
          SRC_FRAMED:   rl = serial_level();
          SRC_LOOPBACK: rl = model_tx_line;
          default:      rl = ($urandom_range(0, 3) != 0);
        endcase
        send_tick($urandom_range(0, 2) == 0, 8'($urandom), rl);
      end
      sent += seg_len;
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    reset_model();

    test_reset_state();
    test_corner_cases();
    test_long_period();
    test_backpressure();
    test_random_traffic();

    // drop valid, drain every prediction, then give the output register time to settle
    in_valid <= 1'b0;
    while (tick_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
